### design/assert_macros.svh
// assertion helpers used by circular_list_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define CLE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in one cycle implies consequence in the next
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Constants and codes of the circular list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

    localparam int CAP   = 64;
    localparam int IDX_W = $clog2(CAP);
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int VAL_W = 32;

    localparam logic [3:0] CMD_INS_FRONT = 4'd0;
    localparam logic [3:0] CMD_INS_END   = 4'd1;
    localparam logic [3:0] CMD_INS_POS   = 4'd2;
    localparam logic [3:0] CMD_INS_ORD   = 4'd3;
    localparam logic [3:0] CMD_DEL_FRONT = 4'd4;
    localparam logic [3:0] CMD_DEL_END   = 4'd5;
    localparam logic [3:0] CMD_DEL_POS   = 4'd6;
    localparam logic [3:0] CMD_DEL_KEY   = 4'd7;
    localparam logic [3:0] CMD_SEARCH    = 4'd8;
    localparam logic [3:0] CMD_REVERSE   = 4'd9;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BAD_POS  = 3'd2;
    localparam logic [2:0] ST_NO_KEY   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

endpackage

`default_nettype wire

### design/cle_req_if.sv
// ----------------------------------------------------------------------------
// cle_req_if
// Command channel of the circular list engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface cle_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [31:0] item_value;
    logic [6:0]  position;

    modport source (output valid, command, item_value, position, input ready);
    modport sink (input valid, command, item_value, position, output ready);
endinterface

`default_nettype wire

### design/cle_rsp_if.sv
// ----------------------------------------------------------------------------
// cle_rsp_if
// Result channel of the circular list engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface cle_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_value;
    logic [6:0]  found_position;
    logic [6:0]  list_length;

    modport source (output valid, status, result_value, found_position, list_length,
                    input ready);
    modport sink (input valid, status, result_value, found_position, list_length,
                  output ready);
endinterface

`default_nettype wire

### design/circular_list_engine.sv
// ----------------------------------------------------------------------------
// circular_list_engine
// Bounded circular singly linked list kept in a node pool of two memories.
// ----------------------------------------------------------------------------
// Usage: one command beat on req gives exactly one result beat on rsp.
// The list lives in a value memory and a link memory, both with a
// registered read; a sequencer walks the links one node per cycle.
// Errors, short reverses and unknown codes finish without a memory access.
// An insert first takes a node from the free chain or from the unused pool.
// Unless the list was empty, a command then reads the tail's link to find
// the head and walks the links as far as it needs, and an insert or delete
// ends by rewriting the links. The longest case is an insert after 63
// nodes.
// Throughput: one command at a time; req.ready is high only while the
// sequencer is idle, from the cycle after the result is loaded. The result
// sits in an output register, so a new command is taken while a result
// still waits on rsp.
// Reset: the list is empty, no node is in use; memory contents are not
// cleared and need no sweep.
// Stall: when rsp.ready is low the finished result waits and the sequencer
// holds in its final state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_engine (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cle_req_if.sink    req,
    cle_rsp_if.source  rsp
);

`include "assert_macros.svh"

    localparam int IW = cle_pkg::IDX_W;
    localparam int CW = cle_pkg::CNT_W;
    localparam int VW = cle_pkg::VAL_W;
    localparam logic [CW-1:0] CAP_C = CW'(cle_pkg::CAP);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ALLOC  = 4'd1;
    localparam logic [3:0] S_ALLOCW = 4'd2;
    localparam logic [3:0] S_START  = 4'd3;
    localparam logic [3:0] S_HEAD   = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_INS    = 4'd6;
    localparam logic [3:0] S_INS2   = 4'd7;
    localparam logic [3:0] S_DEL    = 4'd8;
    localparam logic [3:0] S_DEL2   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [1:0] M_WALK = 2'd0;
    localparam logic [1:0] M_ORD  = 2'd1;
    localparam logic [1:0] M_FIND = 2'd2;
    localparam logic [1:0] M_REV  = 2'd3;

    // node pool memories
    logic [VW-1:0] vals [cle_pkg::CAP];
    logic [IW-1:0] links [cle_pkg::CAP];
    logic [VW-1:0] val_q;
    logic [IW-1:0] link_q;
    logic [IW-1:0] rd_addr, wr_addr, wr_link;
    logic          link_we, val_we;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    cmd_reg, cmd_next;
    logic [VW-1:0] v_reg, v_next;
    logic [1:0]    mode_reg, mode_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic          front_reg, front_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] free_reg, free_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [IW-1:0] node_reg, node_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [2:0]    st_reg, st_next;
    logic [VW-1:0] rv_reg, rv_next;
    logic [CW-1:0] fp_reg, fp_next;
    logic          ov_reg, ov_next;
    logic [2:0]    ost_reg, ost_next;
    logic [VW-1:0] orv_reg, orv_next;
    logic [CW-1:0] ofp_reg, ofp_next;
    logic [CW-1:0] olen_reg, olen_next;

    logic          accept;
    logic          free_ok;
    logic          stop_ord;
    logic          cnt_hold;

    assign accept  = req.valid && req.ready;
    assign free_ok = (free_reg < CAP_C);
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid          = ov_reg;
    assign rsp.status         = ost_reg;
    assign rsp.result_value   = orv_reg;
    assign rsp.found_position = ofp_reg;
    assign rsp.list_length    = olen_reg;

    // ordered insert goes first if below head, else before next value >= it
    assign stop_ord = (idx_reg == '0) ? ($signed(v_reg) < $signed(val_q))
                    : ((idx_reg == cnt_reg) || !($signed(val_q) < $signed(v_reg)));

    // count may change only in the last insert or delete step
    assign cnt_hold = (state_reg != S_INS2) && (state_reg != S_DEL2);

    // memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            links[wr_addr] <= wr_link;
        end
        if (val_we)
        begin
            vals[wr_addr] <= v_reg;
        end
        link_q <= links[rd_addr];
        val_q  <= vals[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        v_next     = v_reg;
        mode_next  = mode_reg;
        limit_next = limit_reg;
        front_next = front_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        fresh_next = fresh_reg;
        node_next  = node_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        rv_next    = rv_reg;
        fp_next    = fp_reg;
        ov_next    = ov_reg && !rsp.ready;
        ost_next   = ost_reg;
        orv_next   = orv_reg;
        ofp_next   = ofp_reg;
        olen_next  = olen_reg;
        rd_addr    = cur_reg;
        wr_addr    = cur_reg;
        wr_link    = prev_reg;
        link_we    = 1'b0;
        val_we     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.command;
                    v_next     = req.item_value;
                    st_next    = cle_pkg::ST_OK;
                    rv_next    = '0;
                    fp_next    = '0;
                    mode_next  = M_WALK;
                    limit_next = '0;
                    front_next = 1'b0;
                    state_next = S_DONE;
                    case (req.command)
                        cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_END:
                        begin
                            front_next = (req.command == cle_pkg::CMD_INS_FRONT);
                            if (cnt_reg >= CAP_C)
                            begin
                                st_next = cle_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        cle_pkg::CMD_INS_POS:
                        begin
                            front_next = (req.position == 7'd1);
                            limit_next = CW'(req.position - 7'd1);
                            if (req.position == '0
                                || {1'b0, req.position} > ({1'b0, cnt_reg} + 8'd1))
                            begin
                                st_next = cle_pkg::ST_BAD_POS;
                            end
                            else if (cnt_reg >= CAP_C)
                            begin
                                st_next = cle_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        cle_pkg::CMD_INS_ORD:
                        begin
                            mode_next = M_ORD;
                            if (cnt_reg >= CAP_C)
                            begin
                                st_next = cle_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_END:
                        begin
                            limit_next = (req.command == cle_pkg::CMD_DEL_END)
                                       ? cnt_reg - 1'b1 : '0;
                            if (cnt_reg == '0)
                            begin
                                st_next = cle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_START;
                            end
                        end
                        cle_pkg::CMD_DEL_POS:
                        begin
                            limit_next = CW'(req.position - 7'd1);
                            if (cnt_reg == '0)
                            begin
                                st_next = cle_pkg::ST_EMPTY;
                            end
                            else if (req.position == '0 || req.position > cnt_reg)
                            begin
                                st_next = cle_pkg::ST_BAD_POS;
                            end
                            else
                            begin
                                state_next = S_START;
                            end
                        end
                        cle_pkg::CMD_DEL_KEY, cle_pkg::CMD_SEARCH:
                        begin
                            mode_next = M_FIND;
                            if (cnt_reg == '0)
                            begin
                                st_next = cle_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_START;
                            end
                        end
                        cle_pkg::CMD_REVERSE:
                        begin
                            mode_next = M_REV;
                            if (cnt_reg >= CW'(2))
                            begin
                                state_next = S_START;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // read the link of the free chain head
            S_ALLOC:
            begin
                rd_addr    = free_reg[IW-1:0];
                state_next = S_ALLOCW;
            end

            // take a node from the free chain, else a fresh one
            S_ALLOCW:
            begin
                if (free_ok)
                begin
                    node_next = free_reg[IW-1:0];
                    free_next = (link_q == free_reg[IW-1:0]) ? CAP_C : {1'b0, link_q};
                end
                else
                begin
                    node_next  = fresh_reg[IW-1:0];
                    fresh_next = fresh_reg + 1'b1;
                end
                if (cnt_reg == '0)
                begin
                    prev_next  = node_next;
                    cur_next   = node_next;
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_START;
                end
            end

            S_START:
            begin
                rd_addr    = tail_reg;
                state_next = S_HEAD;
            end

            S_HEAD:
            begin
                prev_next  = tail_reg;
                cur_next   = link_q;
                head_next  = link_q;
                idx_next   = '0;
                rd_addr    = link_q;
                state_next = S_SCAN;
            end

            // one node a cycle: val_q and link_q belong to cur_reg
            S_SCAN:
            begin
                case (mode_reg)
                    M_WALK:
                    begin
                        if (idx_reg == limit_reg)
                        begin
                            state_next = (cmd_reg <= cle_pkg::CMD_INS_ORD) ? S_INS : S_DEL;
                        end
                        else
                        begin
                            prev_next = cur_reg;
                            cur_next  = link_q;
                            idx_next  = idx_reg + 1'b1;
                            rd_addr   = link_q;
                        end
                    end
                    M_ORD:
                    begin
                        if (stop_ord)
                        begin
                            front_next = (idx_reg == '0);
                            state_next = S_INS;
                        end
                        else
                        begin
                            prev_next = cur_reg;
                            cur_next  = link_q;
                            idx_next  = idx_reg + 1'b1;
                            rd_addr   = link_q;
                        end
                    end
                    M_FIND:
                    begin
                        if (idx_reg == cnt_reg)
                        begin
                            st_next    = cle_pkg::ST_NO_KEY;
                            state_next = S_DONE;
                        end
                        else if (val_q == v_reg)
                        begin
                            if (cmd_reg == cle_pkg::CMD_DEL_KEY)
                            begin
                                state_next = S_DEL;
                            end
                            else
                            begin
                                rv_next    = v_reg;
                                fp_next    = idx_reg + 1'b1;
                                state_next = S_DONE;
                            end
                        end
                        else
                        begin
                            prev_next = cur_reg;
                            cur_next  = link_q;
                            idx_next  = idx_reg + 1'b1;
                            rd_addr   = link_q;
                        end
                    end
                    default:
                    begin
                        // reverse: point each node back at its predecessor
                        if (idx_reg == cnt_reg)
                        begin
                            tail_next  = head_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            link_we   = 1'b1;
                            wr_addr   = cur_reg;
                            wr_link   = prev_reg;
                            prev_next = cur_reg;
                            cur_next  = link_q;
                            idx_next  = idx_reg + 1'b1;
                            rd_addr   = link_q;
                        end
                    end
                endcase
            end

            // new node points at the successor and takes the value
            S_INS:
            begin
                link_we    = 1'b1;
                val_we     = 1'b1;
                wr_addr    = node_reg;
                wr_link    = cur_reg;
                state_next = S_INS2;
            end

            S_INS2:
            begin
                link_we = 1'b1;
                wr_addr = prev_reg;
                wr_link = node_reg;
                if (cnt_reg == '0 || (!front_reg && prev_reg == tail_reg))
                begin
                    tail_next = node_reg;
                end
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_DONE;
            end

            // unlink the node after prev_reg
            S_DEL:
            begin
                rv_next = val_q;
                link_we = 1'b1;
                wr_addr = prev_reg;
                wr_link = link_q;
                if (cur_reg == tail_reg)
                begin
                    tail_next = prev_reg;
                end
                state_next = S_DEL2;
            end

            // push the freed node onto the free chain
            S_DEL2:
            begin
                link_we    = 1'b1;
                wr_addr    = cur_reg;
                wr_link    = free_ok ? free_reg[IW-1:0] : cur_reg;
                free_next  = {1'b0, cur_reg};
                cnt_next   = cnt_reg - 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    orv_next   = rv_reg;
                    ofp_next   = fp_reg;
                    olen_next  = cnt_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
            v_reg     <= '0;
            mode_reg  <= M_WALK;
            limit_reg <= '0;
            front_reg <= 1'b0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            free_reg  <= CAP_C;
            fresh_reg <= '0;
            node_reg  <= '0;
            prev_reg  <= '0;
            cur_reg   <= '0;
            head_reg  <= '0;
            idx_reg   <= '0;
            st_reg    <= cle_pkg::ST_OK;
            rv_reg    <= '0;
            fp_reg    <= '0;
            ov_reg    <= 1'b0;
            ost_reg   <= cle_pkg::ST_OK;
            orv_reg   <= '0;
            ofp_reg   <= '0;
            olen_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            v_reg     <= v_next;
            mode_reg  <= mode_next;
            limit_reg <= limit_next;
            front_reg <= front_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            node_reg  <= node_next;
            prev_reg  <= prev_next;
            cur_reg   <= cur_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            st_reg    <= st_next;
            rv_reg    <= rv_next;
            fp_reg    <= fp_next;
            ov_reg    <= ov_next;
            ost_reg   <= ost_next;
            orv_reg   <= orv_next;
            ofp_reg   <= ofp_next;
            olen_reg  <= olen_next;
        end
    end

    // checks
    `CLE_ASSERT_ALWAYS(a_cnt_bound, (cnt_reg <= CAP_C) && (fresh_reg <= CAP_C), "pool overrun")
    `CLE_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE, "idle after accept")
    `CLE_ASSERT_NEXT(a_cnt_step, cnt_hold, cnt_reg == $past(cnt_reg), "count changed")

endmodule

`default_nettype wire

### verif/cle_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cle_list_checker
// Watches the command and result channels of the circular list engine, keeps
// its own ordered copy of the list, works out the result of every accepted
// command and compares it field by field with the result beats in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_list_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    cle_req_if        req,
    cle_rsp_if        rsp,
    output int        fail_count,
    output int        results_owed
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [6:0]  found_pos;
        logic [6:0]  length;
    } list_result_t;

    // list contents, front first
    logic signed [cle_pkg::VAL_W-1:0] list_vals[$];
    list_result_t                     owed_results[$];

    // index where an ordered insert lands
    function automatic int ordered_slot(logic signed [cle_pkg::VAL_W-1:0] v);
        int j;
        if (list_vals.size() == 0 || v < list_vals[0])
            return 0;
        j = 1;
        while (j < list_vals.size() && list_vals[j] < v)
            j++;
        return j;
    endfunction

    function automatic int key_index(logic signed [cle_pkg::VAL_W-1:0] v);
        foreach (list_vals[k])
            if (list_vals[k] == v)
                return k;
        return -1;
    endfunction

    // apply one command to the list copy and give its result
    function automatic list_result_t apply_command(logic [3:0] cmd, logic [31:0] raw_val,
                                                   logic [6:0] pos);
        list_result_t                     r;
        logic signed [cle_pkg::VAL_W-1:0] v;
        int                               cnt;
        int                               k;
        logic signed [cle_pkg::VAL_W-1:0] rev[$];
        r   = '0;
        v   = raw_val;
        cnt = list_vals.size();
        case (cmd)
            cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_END, cle_pkg::CMD_INS_ORD:
            begin
                if (cnt >= cle_pkg::CAP)
                    r.status = cle_pkg::ST_FULL;
                else if (cmd == cle_pkg::CMD_INS_FRONT)
                    list_vals.push_front(v);
                else if (cmd == cle_pkg::CMD_INS_END)
                    list_vals.push_back(v);
                else
                    list_vals.insert(ordered_slot(v), v);
            end
            cle_pkg::CMD_INS_POS:
            begin
                if (pos < 1 || pos > cnt + 1)
                    r.status = cle_pkg::ST_BAD_POS;
                else if (cnt >= cle_pkg::CAP)
                    r.status = cle_pkg::ST_FULL;
                else
                    list_vals.insert(pos - 1, v);
            end
            cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_END, cle_pkg::CMD_DEL_POS:
            begin
                if (cnt == 0)
                    r.status = cle_pkg::ST_EMPTY;
                else if (cmd == cle_pkg::CMD_DEL_POS && (pos < 1 || pos > cnt))
                    r.status = cle_pkg::ST_BAD_POS;
                else
                begin
                    k = (cmd == cle_pkg::CMD_DEL_FRONT) ? 0
                      : (cmd == cle_pkg::CMD_DEL_END) ? cnt - 1 : pos - 1;
                    r.value = list_vals[k];
                    list_vals.delete(k);
                end
            end
            cle_pkg::CMD_DEL_KEY, cle_pkg::CMD_SEARCH:
            begin
                if (cnt == 0)
                    r.status = cle_pkg::ST_EMPTY;
                else
                begin
                    k = key_index(v);
                    if (k < 0)
                        r.status = cle_pkg::ST_NO_KEY;
                    else
                    begin
                        r.value = list_vals[k];
                        if (cmd == cle_pkg::CMD_DEL_KEY)
                            list_vals.delete(k);
                        else
                            r.found_pos = 7'(k + 1);
                    end
                end
            end
            cle_pkg::CMD_REVERSE:
            begin
                foreach (list_vals[j])
                    rev.push_front(list_vals[j]);
                list_vals = rev;
            end
            default:
            begin
            end
        endcase
        r.length = 7'(list_vals.size());
        return r;
    endfunction

    // result beats are checked before the command of the same edge is added
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t e;
        if (!rst_n)
        begin
            fail_count   <= 0;
            results_owed <= 0;
            list_vals.delete();
            owed_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = owed_results.pop_front();
                    if (rsp.status !== e.status)
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                    if (rsp.result_value !== e.value)
                        $error("result_value: expected %0d, got %0d",
                               $signed(e.value), $signed(rsp.result_value));
                    if (rsp.found_position !== e.found_pos)
                        $error("found_position: expected %0d, got %0d",
                               e.found_pos, rsp.found_position);
                    if (rsp.list_length !== e.length)
                        $error("list_length: expected %0d, got %0d",
                               e.length, rsp.list_length);
                    if (rsp.status !== e.status || rsp.result_value !== e.value ||
                        rsp.found_position !== e.found_pos || rsp.list_length !== e.length)
                        fail_count <= fail_count + 1;
                end
            end
            if (req.valid && req.ready)
                owed_results.push_back(apply_command(req.command, req.item_value,
                                                     req.position));
            results_owed <= owed_results.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb_circular_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_list_engine
// Drives commands into the circular list engine: a directed pass over empty,
// single and small lists, every error but ST_FULL, then random commands in
// growing and shrinking phases, with bursty input, random output stalls and
// one long output hold. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_list_engine;

    localparam int RANDOM_CMDS = 1500;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 2 * cle_pkg::CAP + 20;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   results_owed;
    int   cycle_count = 0;
    int   hold_cycles = 0;
    bit   hold_done = 1'b0;
    bit   stall_free = 1'b0;

    cle_req_if req ();
    cle_rsp_if rsp ();

    circular_list_engine dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    cle_list_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .results_owed(results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off while commands are offered
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            rsp.ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (!hold_done && cycle_count > 2000 && req.valid)
        begin
            rsp.ready   <= 1'b0;
            hold_cycles <= 600;
            hold_done   <= 1'b1;
        end
        else if (stall_free)
            rsp.ready <= 1'b1;
        else
            rsp.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
        if (cycle_count % 3000 == 0)
            stall_free <= ($urandom_range(0, 2) == 0);

    // one command beat; ready is sampled at the falling edge, where it is settled
    task automatic send_beat(logic [3:0] cmd, logic [31:0] v, logic [6:0] pos);
        bit took;
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.item_value <= v;
        req.position   <= pos;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = req.ready;
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return $urandom();
            default: return 32'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    function automatic logic [6:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return 7'($urandom_range(0, 127));
            1, 2:    return 7'($urandom_range(58, 66));
            default: return 7'($urandom_range(0, 12));
        endcase
    endfunction

    // inserts outweigh deletes when growing, the other way when shrinking
    function automatic logic [3:0] pick_cmd(bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 4'($urandom_range(10, 15));
        if (r < 10)
            return cle_pkg::CMD_REVERSE;
        if (r < 20)
            return cle_pkg::CMD_SEARCH;
        if (r < (growing ? 75 : 40))
            return 4'($urandom_range(cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_ORD));
        return 4'($urandom_range(cle_pkg::CMD_DEL_FRONT, cle_pkg::CMD_DEL_KEY));
    endfunction

    initial
    begin
        int burst;
        bit growing;
        req.valid      <= 1'b0;
        req.command    <= cle_pkg::CMD_INS_FRONT;
        req.item_value <= '0;
        req.position   <= '0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: each delete, lookup, bad position, reverse; then small lists
        send_beat(cle_pkg::CMD_DEL_FRONT, 32'd0, 7'd0);
        send_beat(cle_pkg::CMD_DEL_END, 32'd0, 7'd0);
        send_beat(cle_pkg::CMD_DEL_POS, 32'd0, 7'd0);
        send_beat(cle_pkg::CMD_DEL_KEY, 32'd5, 7'd0);
        send_beat(cle_pkg::CMD_SEARCH, 32'd5, 7'd0);
        send_beat(cle_pkg::CMD_REVERSE, 32'd0, 7'd0);
        send_beat(cle_pkg::CMD_INS_POS, 32'd1, 7'd0);
        send_beat(cle_pkg::CMD_INS_POS, 32'd1, 7'd2);
        send_beat(cle_pkg::CMD_INS_POS, 32'd7, 7'd1);
        send_beat(cle_pkg::CMD_REVERSE, 32'd0, 7'd0);
        send_beat(cle_pkg::CMD_INS_FRONT, 32'h7fff_ffff, 7'd127);
        send_beat(cle_pkg::CMD_INS_END, 32'h8000_0000, 7'd0);
        send_beat(cle_pkg::CMD_INS_ORD, 32'hffff_ffff, 7'd0);
        send_beat(cle_pkg::CMD_INS_ORD, 32'h8000_0000, 7'd0);
        send_beat(cle_pkg::CMD_SEARCH, 32'h8000_0000, 7'd0);
        send_beat(cle_pkg::CMD_SEARCH, 32'd3, 7'd0);
        send_beat(cle_pkg::CMD_REVERSE, 32'd0, 7'd0);
        send_beat(cle_pkg::CMD_DEL_KEY, 32'd7, 7'd0);
        send_beat(cle_pkg::CMD_DEL_KEY, 32'd9, 7'd0);
        send_beat(cle_pkg::CMD_DEL_POS, 32'd0, 7'd4);
        send_beat(cle_pkg::CMD_DEL_POS, 32'd0, 7'd2);
        send_beat(cle_pkg::CMD_INS_POS, 32'd2, 7'd127);
        send_beat(4'd15, 32'd0, 7'd0);
        send_beat(4'd10, 32'hffff_ffff, 7'h7f);
        send_beat(cle_pkg::CMD_DEL_END, 32'd0, 7'd0);

        // random phases alternate between growing and shrinking the list
        for (int n = 0; n < RANDOM_CMDS; n += burst)
        begin
            growing = ((n / 250) % 2 == 0);
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst; b++)
                send_beat(pick_cmd(growing), pick_value(), pick_pos());
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        req.valid <= 1'b0;

        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
